/* rtl/core/cvds_pkg.sv */
// Package: shared types, constants and control structs for depth select.
`timescale 1ns / 1ps
package cvds_pkg;

  localparam int DEPTH_MAX_DEF = 256;
  localparam int COST_BITS_DEF = 16;

  localparam logic [2:0] CFG_DEPTH_COUNT = 3'd0;
  localparam logic [2:0] CFG_FOCUS_THR   = 3'd1;
  localparam logic [2:0] CFG_HALF_WIN    = 3'd2;
  localparam logic [2:0] CFG_MAX_VAR     = 3'd3;
  localparam logic [2:0] CFG_MODE        = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FOCUS = 2'd1;
  localparam logic [1:0] STATUS_REJECT   = 2'd2;

  typedef struct packed {
    logic [15:0] consistency_cost;
    logic [15:0] focus_score;
  } in_word_t;

  typedef struct packed {
    logic [7:0] depth_index;
    logic [1:0] pixel_status;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // take an input word
    logic var_start;   // latch mean, reset pass index
    logic var_step;    // issue one store read
    logic decide;      // form result word
    logic clear;       // restore per-pixel trackers
  } cvds_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_depth;  // accepted word closes the pixel
    logic mean_done;   // mean divider finished
    logic var_last;    // last read issued
    logic var_done;    // accumulation finished
  } cvds_sts_t;

endpackage

/* rtl/core/cvds_ctrl.sv */
// Controller: sequences the streaming, mean, variance and result phases.
`timescale 1ns / 1ps
module cvds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  cvds_pkg::cvds_sts_t sts_i,
  output cvds_pkg::cvds_cmd_t cmd_o
);

  localparam logic [2:0] S_STREAM = 3'd0;
  localparam logic [2:0] S_MEAN   = 3'd1;
  localparam logic [2:0] S_VAR    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // output register frees as soon as taken; decide waits for a free slot
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_STREAM: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.last_depth) state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        if (sts_i.mean_done) begin
          cmd_o.var_start = 1'b1;
          state_d = S_VAR;
        end
      end
      S_VAR: begin
        cmd_o.var_step = 1'b1;
        if (sts_i.var_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts_i.var_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          cmd_o.decide = 1'b1;
          cmd_o.clear  = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_STREAM;
        end
      end
      default: state_d = S_STREAM;
    endcase
  end

  assign in_stall_o  = (state_q != S_STREAM);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_STREAM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_decide_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |-> out_free)
    else $error("result formed while output slot busy");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_STREAM) |-> !cmd_o.accept)
    else $error("word accepted outside stream phase");
  a_decide_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |=> out_valid_q)
    else $error("result not presented after decide");

endmodule

/* rtl/core/cvds_dp.sv */
// Datapath: trackers, cost store, mean divider, variance accumulator, decision.
`timescale 1ns / 1ps
module cvds_dp #(
  parameter int DEPTH_MAX = cvds_pkg::DEPTH_MAX_DEF,
  parameter int COST_BITS = cvds_pkg::COST_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  cvds_pkg::in_word_t   in_word_i,
  input  cvds_pkg::cvds_cmd_t  cmd_i,
  output cvds_pkg::cvds_sts_t  sts_o,
  output cvds_pkg::out_word_t  out_word_o
);

  localparam int AW   = $clog2(DEPTH_MAX);
  localparam int CW   = AW + 1;              // holds DEPTH_MAX itself
  localparam int SW   = COST_BITS + CW;      // cost sum width
  localparam int QW   = 2 * COST_BITS;       // square width
  localparam int AccW = QW + CW;             // never saturates
  localparam int DCW  = $clog2(SW + 1);
  localparam int CMPW = (AccW + 1 > 41) ? AccW + 1 : 41;
  // low bound after reset follows the reset depth count
  localparam int LO_RST = (64 > DEPTH_MAX) ? DEPTH_MAX : 64;

  // configuration
  logic [8:0]  depth_count_q;
  logic [15:0] focus_thr_q;
  logic [8:0]  half_win_q;
  logic [31:0] max_var_q;
  logic [4:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_count_q <= 9'd64;
      focus_thr_q   <= '0;
      half_win_q    <= 9'd4;
      max_var_q     <= '0;
      mode_q        <= 5'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cvds_pkg::CFG_DEPTH_COUNT: depth_count_q <= cfg_data_i[8:0];
        cvds_pkg::CFG_FOCUS_THR:   focus_thr_q   <= cfg_data_i[15:0];
        cvds_pkg::CFG_HALF_WIN:    half_win_q    <= cfg_data_i[8:0];
        cvds_pkg::CFG_MAX_VAR:     max_var_q     <= cfg_data_i;
        cvds_pkg::CFG_MODE:        mode_q        <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // effective count in 1..DEPTH_MAX
  logic [CW-1:0] n_eff;
  always_comb begin
    if (depth_count_q == '0) n_eff = CW'(1);
    else if (int'(depth_count_q) > DEPTH_MAX) n_eff = CW'(DEPTH_MAX);
    else n_eff = CW'(depth_count_q);
  end

  logic [COST_BITS-1:0] cc, fc;
  assign cc = in_word_i.consistency_cost[COST_BITS-1:0];
  assign fc = in_word_i.focus_score[COST_BITS-1:0];

  // per-pixel trackers
  logic [CW-1:0]        cnt_q;
  logic [COST_BITS-1:0] best_cost_q, peak_q;
  logic [AW-1:0]        best_depth_q, peak_depth_q, hi_q;
  logic [CW-1:0]        lo_q;
  logic [SW-1:0]        sum_q;
  logic                 seen_q;

  logic [AW-1:0] d;
  assign d = cnt_q[AW-1:0];
  logic fhit;
  assign fhit = (32'(fc) >= 32'(focus_thr_q)) && (fc != '0);
  assign sts_o.last_depth = (cnt_q + CW'(1)) >= n_eff;

  // low bound starts at the count in force when the trackers are cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; best_cost_q <= '1; best_depth_q <= '0; sum_q <= '0;
      seen_q <= 1'b0; lo_q <= CW'(LO_RST); hi_q <= '0;
      peak_q <= '0; peak_depth_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_q <= '0; best_cost_q <= '1; best_depth_q <= '0; sum_q <= '0;
      seen_q <= 1'b0; lo_q <= n_eff; hi_q <= '0;
      peak_q <= '0; peak_depth_q <= '0;
    end else if (cmd_i.accept) begin
      if (!sts_o.last_depth) cnt_q <= cnt_q + CW'(1);
      if (cc < best_cost_q) begin
        best_cost_q  <= cc;
        best_depth_q <= d;
      end
      sum_q <= sum_q + SW'(cc);
      if (fhit) begin
        seen_q <= 1'b1;
        if (CW'(d) < lo_q) lo_q <= CW'(d);
        if (d > hi_q) hi_q <= d;
        if (fc > peak_q) begin
          peak_q       <= fc;
          peak_depth_q <= d;
        end
      end
    end
  end

  // cost store
  logic [COST_BITS-1:0] store_mem [DEPTH_MAX];
  logic [COST_BITS-1:0] rd_q;
  logic [AW-1:0]        rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) store_mem[d] <= cc;
    rd_q <= store_mem[rd_addr];
  end

  // restoring divider for mean = sum / n, one bit per cycle
  logic [SW-1:0]   quo_q;
  logic [CW:0]     rem_q;
  logic [DCW-1:0]  div_cnt_q;
  logic            div_run_q;
  logic [CW:0]     rem_sh;
  assign rem_sh = {rem_q[CW-1:0], quo_q[SW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q <= 1'b0;
      div_cnt_q <= '0;
    end else if (cmd_i.accept && sts_o.last_depth) begin
      div_run_q <= 1'b1;
      div_cnt_q <= '0;
    end else if (div_run_q) begin
      div_cnt_q <= div_cnt_q + DCW'(1);
      if (div_cnt_q == DCW'(SW - 1)) div_run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sts_o.last_depth) begin
      quo_q <= sum_q + SW'(cc);
      rem_q <= '0;
    end else if (div_run_q) begin
      if (rem_sh >= {1'b0, n_eff}) begin
        rem_q <= rem_sh - {1'b0, n_eff};
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
  end
  assign sts_o.mean_done = !div_run_q;

  // variance pass: address issue, registered read, diff, square, accumulate
  logic [COST_BITS-1:0] mean_q;
  logic [CW-1:0]        va_q;
  logic                 v1_q, v2_q, v3_q;   // pipeline valids
  logic                 in1_q, in2_q, in3_q;
  logic [COST_BITS-1:0] diff_q;
  logic [QW-1:0]        sq_q;
  logic [AccW-1:0]      acc_q;

  assign rd_addr = va_q[AW-1:0];
  assign sts_o.var_last = cmd_i.var_step && (va_q + CW'(1) >= n_eff);
  assign sts_o.var_done = !(v1_q || v2_q || v3_q);

  // strictly inside window: va + hw > best and va < best + hw
  logic in_win;
  assign in_win = (int'(va_q) + int'(half_win_q) > int'(best_depth_q)) &&
                  (int'(va_q) < int'(best_depth_q) + int'(half_win_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      {v1_q, v2_q, v3_q} <= '0;
    end else begin
      if (cmd_i.var_start) va_q <= '0;
      else if (cmd_i.var_step) va_q <= va_q + CW'(1);
      v1_q <= cmd_i.var_step;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // v1: read data, v2: difference, v3: square
  always_ff @(posedge clk_i) begin
    if (cmd_i.var_start) begin
      mean_q <= quo_q[COST_BITS-1:0];
      acc_q  <= '0;
    end else if (v3_q && in3_q) begin
      acc_q <= acc_q + AccW'(sq_q);
    end
    in1_q <= in_win;
    in2_q <= in1_q;
    in3_q <= in2_q;
    diff_q <= (rd_q >= mean_q) ? rd_q - mean_q : mean_q - rd_q;
    sq_q   <= diff_q * diff_q;
  end

  // decision: 2*acc < max_var*hw, one multiply registered at pass start
  logic [40:0] thr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.var_start) thr_q <= max_var_q * half_win_q;
  end

  logic uc, uf, rej_focus, rej_other;
  logic [AccW:0] acc2;
  assign acc2 = {acc_q, 1'b0};
  assign uc = mode_q[0];
  assign uf = mode_q[1];
  assign rej_focus = uf && mode_q[2] && !seen_q;
  assign rej_other = (uc && uf && mode_q[3] &&
                      ((CW'(best_depth_q) < lo_q) || (best_depth_q > hi_q))) ||
                     (mode_q[4] && (CMPW'(acc2) < CMPW'(thr_q)));

  cvds_pkg::out_word_t out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      priority if (rej_focus) begin
        out_q.depth_index  <= '0;
        out_q.pixel_status <= cvds_pkg::STATUS_NO_FOCUS;
      end else if (rej_other) begin
        out_q.depth_index  <= '0;
        out_q.pixel_status <= cvds_pkg::STATUS_REJECT;
      end else if (uf && !uc) begin
        out_q.depth_index  <= 8'(peak_depth_q);
        out_q.pixel_status <= cvds_pkg::STATUS_OK;
      end else begin
        out_q.depth_index  <= 8'(best_depth_q);
        out_q.pixel_status <= cvds_pkg::STATUS_OK;
      end
    end
  end
  assign out_word_o = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> cnt_q < n_eff || cnt_q == '0)
    else $error("depth counter beyond count");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.var_start |-> !div_run_q)
    else $error("variance pass started before mean ready");
  a_pipe_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |=> v3_q)
    else $error("variance pipeline lost a sample");

endmodule

/* rtl/core/cost_volume_depth_select.sv */
// Per pixel of N depths: N accepted words, the bit-serial mean divider over the
// SW-bit sum (SW = COST_BITS + clog2(DEPTH_MAX) + 1), N store reads, a drain of
// the variance pipeline, then a decide step that waits for a free output slot.
// The single store read port and the divider serve one pixel at a time: input
// stalls outside the stream phase until the current result word is formed.
// Reset (async, active low) restores config, state and trackers, not the store.
`timescale 1ns / 1ps
module cost_volume_depth_select #(
  parameter int DEPTH_MAX = cvds_pkg::DEPTH_MAX_DEF,
  parameter int COST_BITS = cvds_pkg::COST_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cvds_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cvds_pkg::out_word_t out_data_o
);

  cvds_pkg::cvds_cmd_t cmd;
  cvds_pkg::cvds_sts_t sts;

  cvds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cvds_dp #(
    .DEPTH_MAX (DEPTH_MAX),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_data_o)
  );

endmodule
